// File: sv/lr_pkg.sv
// Shared constants and types for the line rasterizer.
// Used by the front, queue, back, top-level and checker files; depends on nothing.
package lr_pkg;

  localparam int COORD_BITS_DEFAULT = 10;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic is_step;
    logic steep;
    logic minor_down;
  } lr_flags_t;

  localparam int FLAGS_BITS = $bits(lr_flags_t);

endpackage

// File: sv/line_rasterizer.sv
// Top level of the Bresenham line rasterizer: front setup, queue and back stepper.
// Depends on lr_pkg, lr_front, lr_queue and lr_back.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | kind, start_x, start_y, end_x, end_y
//   out     | output    | out_valid / out_stall | pixel_x, pixel_y, last
//
// One item is accepted every cycle while the two-entry queue has room.
// A step item's pixel passes through a queue entry and is then written to the result register.
// Line setup is done in the front in the cycle of acceptance; each pixel is one
// subtract, one conditional add and one compare in the back.
// Reset empties the queue, clears the result register and leaves the block idle.
// A stalled result holds the back, and the queue then fills and stalls the input.
module line_rasterizer #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last
);

  localparam int ENTRY_BITS = lr_pkg::FLAGS_BITS + 5 * COORD_BITS;

  lr_pkg::lr_flags_t     f_flags;
  logic [COORD_BITS-1:0] f_major_pos;
  logic [COORD_BITS-1:0] f_major_end;
  logic [COORD_BITS-1:0] f_minor_pos;
  logic [COORD_BITS-1:0] f_major_span;
  logic [COORD_BITS-1:0] f_minor_span;
  logic [ENTRY_BITS-1:0] q_push_data;
  logic [ENTRY_BITS-1:0] q_pop_data;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  lr_pkg::lr_flags_t     b_flags;
  logic [COORD_BITS-1:0] b_major_pos;
  logic [COORD_BITS-1:0] b_major_end;
  logic [COORD_BITS-1:0] b_minor_pos;
  logic [COORD_BITS-1:0] b_major_span;
  logic [COORD_BITS-1:0] b_minor_span;

  lr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_kind    (in_kind),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .flags      (f_flags),
    .major_pos  (f_major_pos),
    .major_end  (f_major_end),
    .minor_pos  (f_minor_pos),
    .major_span (f_major_span),
    .minor_span (f_minor_span)
  );

  assign q_push_data = {f_flags, f_major_pos, f_major_end, f_minor_pos,
                        f_major_span, f_minor_span};
  assign in_stall    = q_full;

  lr_queue #(.WIDTH(ENTRY_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  assign {b_flags, b_major_pos, b_major_end, b_minor_pos,
          b_major_span, b_minor_span} = q_pop_data;

  lr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_not_empty),
    .cmd_pop        (q_pop),
    .cmd_flags      (b_flags),
    .cmd_major_pos  (b_major_pos),
    .cmd_major_end  (b_major_end),
    .cmd_minor_pos  (b_minor_pos),
    .cmd_major_span (b_major_span),
    .cmd_minor_span (b_minor_span),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last       (out_last)
  );

endmodule

// File: sv/lr_front.sv
// Front part of the line rasterizer: classifies each item and sets up a loaded line.
// Depends on lr_pkg for the flag struct and item kind codes.
module lr_front #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                  in_kind,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output lr_pkg::lr_flags_t     flags,
  output logic [COORD_BITS-1:0] major_pos,
  output logic [COORD_BITS-1:0] major_end,
  output logic [COORD_BITS-1:0] minor_pos,
  output logic [COORD_BITS-1:0] major_span,
  output logic [COORD_BITS-1:0] minor_span
);

  logic [COORD_BITS-1:0] span_x;
  logic [COORD_BITS-1:0] span_y;
  logic                  steep;
  logic [COORD_BITS-1:0] a_maj;
  logic [COORD_BITS-1:0] a_min;
  logic [COORD_BITS-1:0] b_maj;
  logic [COORD_BITS-1:0] b_min;
  logic [COORD_BITS-1:0] s_maj;
  logic [COORD_BITS-1:0] s_min;
  logic [COORD_BITS-1:0] e_maj;
  logic [COORD_BITS-1:0] e_min;

  always_comb begin
    span_x = (in_start_x > in_end_x) ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
    span_y = (in_start_y > in_end_y) ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
    steep  = span_y > span_x;
    a_maj  = steep ? in_start_y : in_start_x;
    a_min  = steep ? in_start_x : in_start_y;
    b_maj  = steep ? in_end_y   : in_end_x;
    b_min  = steep ? in_end_x   : in_end_y;
    if (a_maj > b_maj) begin
      s_maj = b_maj;
      s_min = b_min;
      e_maj = a_maj;
      e_min = a_min;
    end else begin
      s_maj = a_maj;
      s_min = a_min;
      e_maj = b_maj;
      e_min = b_min;
    end
    flags.is_step    = (in_kind == lr_pkg::KIND_STEP);
    flags.steep      = steep;
    flags.minor_down = !(s_min < e_min);
    major_pos        = s_maj;
    major_end        = e_maj;
    minor_pos        = s_min;
    major_span       = e_maj - s_maj;
    minor_span       = (s_min > e_min) ? (s_min - e_min) : (e_min - s_min);
  end

endmodule

// File: sv/lr_queue.sv
// Short queue between the front and back parts of the line rasterizer.
// Depends on lr_pkg for its depth.
module lr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int DEPTH    = lr_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;

  assign full      = (count_r == CNT_BITS'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/lr_back.sv
// Back part of the line rasterizer: holds the line state, steps the error term
// and drives the result register. Depends on lr_pkg for the flag struct.
module lr_back #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  input  lr_pkg::lr_flags_t     cmd_flags,
  input  logic [COORD_BITS-1:0] cmd_major_pos,
  input  logic [COORD_BITS-1:0] cmd_major_end,
  input  logic [COORD_BITS-1:0] cmd_minor_pos,
  input  logic [COORD_BITS-1:0] cmd_major_span,
  input  logic [COORD_BITS-1:0] cmd_minor_span,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last
);

  localparam int ERR_BITS = COORD_BITS + 2;

  logic                       drawing_r;
  logic                       drawing_nxt;
  logic                       steep_r;
  logic                       minor_down_r;
  logic [COORD_BITS-1:0]      major_pos_r;
  logic [COORD_BITS-1:0]      major_end_r;
  logic [COORD_BITS-1:0]      minor_pos_r;
  logic [COORD_BITS-1:0]      major_span_r;
  logic [COORD_BITS-1:0]      minor_span_r;
  logic signed [ERR_BITS-1:0] err_r;
  logic signed [ERR_BITS-1:0] err_sub;
  logic signed [ERR_BITS-1:0] err_nxt;
  logic [COORD_BITS-1:0]      minor_step;
  logic                       is_last;
  logic                       emit;
  logic                       load;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [COORD_BITS-1:0]      pixel_x_r;
  logic [COORD_BITS-1:0]      pixel_y_r;
  logic                       last_r;

  assign cmd_pop   = cmd_valid && (!out_valid_r || !out_stall);
  assign load      = cmd_pop && !cmd_flags.is_step;
  assign emit      = cmd_pop && cmd_flags.is_step && drawing_r;
  assign is_last   = (major_pos_r == major_end_r);
  assign out_valid = out_valid_r;
  assign out_pixel_x = pixel_x_r;
  assign out_pixel_y = pixel_y_r;
  assign out_last    = last_r;

  always_comb begin
    err_sub    = err_r - $signed({1'b0, minor_span_r, 1'b0});
    err_nxt    = err_sub;
    minor_step = minor_pos_r;
    if (err_sub < 0) begin
      err_nxt    = err_sub + $signed({1'b0, major_span_r, 1'b0});
      minor_step = minor_down_r ? minor_pos_r - 1'b1 : minor_pos_r + 1'b1;
    end
    drawing_nxt = drawing_r;
    if (load) begin
      drawing_nxt = 1'b1;
    end else if (emit && is_last) begin
      drawing_nxt = 1'b0;
    end
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drawing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      drawing_r   <= drawing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      steep_r      <= cmd_flags.steep;
      minor_down_r <= cmd_flags.minor_down;
      major_pos_r  <= cmd_major_pos;
      major_end_r  <= cmd_major_end;
      minor_pos_r  <= cmd_minor_pos;
      major_span_r <= cmd_major_span;
      minor_span_r <= cmd_minor_span;
      err_r        <= $signed({2'b00, cmd_major_span});
    end else if (emit && !is_last) begin
      major_pos_r <= major_pos_r + 1'b1;
      minor_pos_r <= minor_step;
      err_r       <= err_nxt;
    end
    if (emit) begin
      pixel_x_r <= steep_r ? minor_pos_r : major_pos_r;
      pixel_y_r <= steep_r ? major_pos_r : minor_pos_r;
      last_r    <= is_last;
    end
  end

endmodule

// File: sv/lr_checker.sv
// Port-level assertions for the line rasterizer, bound to the top level.
// Depends on line_rasterizer and lr_pkg.
module lr_checker #(
  parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_pixel_x,
  input logic [COORD_BITS-1:0] out_pixel_y,
  input logic                  out_last
);

  // The result register is empty in the cycle after any reset cycle.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result keeps its pixel.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) &&
                               $stable(out_pixel_y) && $stable(out_last))
    else $error("stalled result changed");

  // The queue can only fill through an item offered at the edge before.
  a_stall_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall rose without an item offered");

endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);
